/* sv/cxy2rgb_pkg.sv */
// Shared constants, types and coefficient table for the CIE xy to RGB converter.
package cxy2rgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 8;
  localparam int QW        = IN_W + FRAC_BITS;
  localparam int CW        = FRAC_BITS + 3;
  localparam int PW        = CW + IN_W + 1;
  localparam int SW        = PW + 3;
  localparam int CF_SHIFT  = 24 - FRAC_BITS;
  localparam int NPROD     = 6;

  localparam logic [IN_W-1:0] FULL_SCALE = {IN_W{1'b1}};

  // Round a 24-fraction-bit magnitude half up to FRAC_BITS fraction bits.
  function automatic logic [CW-1:0] coef(input logic [31:0] m);
    logic [32:0] t;
    t = {1'b0, m} + ((33'd1 << CF_SHIFT) >> 1);
    t = t >> CF_SHIFT;
    return t[CW-1:0];
  endfunction

  // Product coefficients: red, green, blue times X, then red, green, blue times Z.
  localparam logic [CW-1:0] COEF [NPROD] = '{
    coef(32'd54365800), coef(32'd16261585), coef(32'd933541),
    coef(32'd8363969),  coef(32'd697194),   coef(32'd17737296)
  };

  // Constant luminance terms, Y fixed at one.
  localparam logic [CW-1:0] C_RY = coef(32'd25788905);
  localparam logic [CW-1:0] C_GY = coef(32'd31474238);
  localparam logic [CW-1:0] C_BY = coef(32'd3422987);

  typedef struct packed {
    logic [IN_W-1:0] y;
    logic [IN_W-1:0] rem_x;
    logic [IN_W-1:0] rem_z;
    logic [QW-1:0]   num_x;
    logic [QW-1:0]   num_z;
    logic            z_neg;
    logic            y_zero;
  } div_stage_t;

endpackage

/* sv/cie_xy_to_rgb_converter_top.sv */
// Pipelined CIE xy chromaticity to linear 8-bit RGB converter.
//
//  channel   | dir | tdata fields (low bit up)         | tuser
//  s_axis    | in  | chroma_x[15:0], chroma_y[31:16]    | -
//  m_axis    | out | red[7:0], green[15:8], blue[23:16] | y_was_zero
//
// One transfer in per cycle while the pipeline is not held, one result out per transfer.
// The two restoring dividers, one quotient bit per stage, set the depth.
// Whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits; payload registers are not reset.
module cie_xy_to_rgb_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // chroma_x[15:0], chroma_y[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic [0:0]  m_axis_tuser    // y_was_zero[0]
);

  localparam int F  = cxy2rgb_pkg::FRAC_BITS;
  localparam int IW = cxy2rgb_pkg::IN_W;
  localparam int QW = cxy2rgb_pkg::QW;
  localparam int CW = cxy2rgb_pkg::CW;
  localparam int PW = cxy2rgb_pkg::PW;
  localparam int SW = cxy2rgb_pkg::SW;
  localparam int NP = cxy2rgb_pkg::NPROD;

  function automatic cxy2rgb_pkg::div_stage_t div_step(input cxy2rgb_pkg::div_stage_t s);
    cxy2rgb_pkg::div_stage_t n;
    logic [IW:0] tx, tz;
    logic        gx, gz;
    n  = s;
    tx = {s.rem_x, s.num_x[QW-1]};
    tz = {s.rem_z, s.num_z[QW-1]};
    gx = tx >= {1'b0, s.y};
    gz = tz >= {1'b0, s.y};
    tx = gx ? tx - {1'b0, s.y} : tx;
    tz = gz ? tz - {1'b0, s.y} : tz;
    n.rem_x = tx[IW-1:0];
    n.rem_z = tz[IW-1:0];
    n.num_x = {s.num_x[QW-2:0], gx};
    n.num_z = {s.num_z[QW-2:0], gz};
    return n;
  endfunction

  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Input stage and divider stages
  logic [IW-1:0]             in_x, in_y;
  logic signed [IW+1:0]      zn;
  logic [IW-1:0]             zn_mag;
  cxy2rgb_pkg::div_stage_t   div_d;
  cxy2rgb_pkg::div_stage_t   div_q [QW+1];
  logic [QW:0]               div_v_q;

  assign in_x   = s_axis_tdata[IW-1:0];
  assign in_y   = s_axis_tdata[2*IW-1:IW];
  assign zn     = $signed({2'b00, cxy2rgb_pkg::FULL_SCALE}) - $signed({2'b00, in_x})
                - $signed({2'b00, in_y});
  // Magnitude never exceeds full scale
  assign zn_mag = zn[IW+1] ? IW'(-zn) : IW'(zn);

  always_comb begin
    div_d        = '0;
    div_d.y      = in_y;
    div_d.num_x  = {in_x, {F{1'b0}}};
    div_d.num_z  = {zn_mag, {F{1'b0}}};
    div_d.z_neg  = zn[IW+1];
    div_d.y_zero = (in_y == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else if (en) begin
      div_v_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= div_d;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[i] <= 1'b0;
      end else if (en) begin
        div_v_q[i] <= div_v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i] <= div_step(div_q[i-1]);
      end
    end
  end

  // Multiply stage: split each quotient into integer and fraction halves
  logic [QW-1:0]      opnd [NP];
  logic [CW+IW-1:0]   ph_q [NP];
  logic [CW+F-1:0]    pl_q [NP];
  logic               mul_v_q, mul_zneg_q, mul_yzero_q;

  for (genvar k = 0; k < NP; k++) begin : g_mul
    assign opnd[k] = (k < 3) ? div_q[QW].num_x : div_q[QW].num_z;

    always_ff @(posedge clk_i) begin
      if (en) begin
        ph_q[k] <= cxy2rgb_pkg::COEF[k] * opnd[k][QW-1:F];
        pl_q[k] <= cxy2rgb_pkg::COEF[k] * opnd[k][F-1:0];
      end
    end
  end

  // Product stage: recombine halves, truncated toward zero on the magnitude
  logic [PW-1:0] p_q [NP];
  logic          prd_v_q, prd_zneg_q, prd_yzero_q;

  for (genvar k = 0; k < NP; k++) begin : g_prd
    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[k] <= PW'(ph_q[k]) + PW'(pl_q[k] >> F);
      end
    end
  end

  // Sum stage: apply coefficient and operand signs
  logic signed [SW-1:0] ps [NP];
  logic signed [SW-1:0] r_d, g_d, b_d;
  logic signed [SW-1:0] r_q, g_q, b_q;
  logic                 sum_v_q, sum_yzero_q;

  for (genvar k = 0; k < NP; k++) begin : g_ext
    assign ps[k] = $signed(SW'(p_q[k]));
  end

  always_comb begin
    r_d = ps[0] - $signed(SW'(cxy2rgb_pkg::C_RY)) + (prd_zneg_q ? ps[3] : -ps[3]);
    g_d = -ps[1] + $signed(SW'(cxy2rgb_pkg::C_GY)) + (prd_zneg_q ? -ps[4] : ps[4]);
    b_d = ps[2] - $signed(SW'(cxy2rgb_pkg::C_BY)) + (prd_zneg_q ? -ps[5] : ps[5]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  // Output stage: clamp to [0, 1], scale by 255 and truncate
  function automatic logic [7:0] to_byte(input logic signed [SW-1:0] s);
    logic [F:0]   c;
    logic [F+8:0] m;
    if (s < 0) begin
      c = '0;
    end else if (s > $signed(SW'(1) <<< F)) begin
      c = (F+1)'(1) << F;
    end else begin
      c = s[F:0];
    end
    m = (F+9)'(c) * (F+9)'(255);
    return m[F+7:F];
  endfunction

  logic [23:0] out_data_q;
  logic        out_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q     <= 1'b0;
      prd_v_q     <= 1'b0;
      sum_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      mul_v_q     <= div_v_q[QW];
      prd_v_q     <= mul_v_q;
      sum_v_q     <= prd_v_q;
      out_valid_q <= sum_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_zneg_q  <= div_q[QW].z_neg;
      mul_yzero_q <= div_q[QW].y_zero;
      prd_zneg_q  <= mul_zneg_q;
      prd_yzero_q <= mul_yzero_q;
      sum_yzero_q <= prd_yzero_q;
      out_zero_q  <= sum_yzero_q;
      // Force black when y was zero
      out_data_q  <= sum_yzero_q ? '0 : {to_byte(b_q), to_byte(g_q), to_byte(r_q)};
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_zero_q;

endmodule

/* sv/cxy2rgb_checker.sv */
// Port-level checker for the CIE xy to RGB converter, bound to the top level.
module cxy2rgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Zero y gives black
  a_zero_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
    else $error("y_was_zero result is not black");

  // Input side advances exactly when the output register can move
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output stall");

  // Valid drops only after a transfer
  a_valid_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result withdrawn without transfer");

endmodule

bind cie_xy_to_rgb_converter_top cxy2rgb_checker u_cxy2rgb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
